@@ design/tkcs_pkg.sv @@
// Package for the typematic key change scanner.
// Field widths, command and report codes, key-entry bit layout and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tkcs_pkg;

  // default number of keys in the table
  localparam int KEY_COUNT_DEF = 256;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 8;
  localparam int KIND_W   = 2;
  localparam int PERIOD_W = 7;
  localparam int DELAY_W  = 10;
  localparam int COUNT_W  = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = DELAY_W;

  // register clamp limits and reset values
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = PERIOD_W'(15);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = PERIOD_W'(100);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(33);
  localparam logic [DELAY_W-1:0]  DELAY_MIN    = DELAY_W'(250);
  localparam logic [DELAY_W-1:0]  DELAY_MAX    = DELAY_W'(1000);
  localparam logic [DELAY_W-1:0]  DELAY_RESET  = DELAY_W'(490);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 1'b1;

  // request commands
  localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FLAG    = 2'd3;

  // report kinds
  localparam logic [KIND_W-1:0] KIND_DOWN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UP     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd2;

  // per-key table entry: repeatable, held, reported
  localparam int ENTRY_W      = 3;
  localparam int BIT_REPORTED = 0;
  localparam int BIT_HELD     = 1;
  localparam int BIT_REPEAT   = 2;

  // divider steps, one dividend bit per step
  localparam int DIV_STEPS = DELAY_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_WAIT,
    S_SCAN
  } tkcs_state_t;

endpackage

`default_nettype wire

@@ design/tkcs_if.sv @@
// Handshake channels of the typematic key change scanner: request in, report out.
// Depends on tkcs_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tkcs_req_if import tkcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] key_code;
  logic             flag_value;

  modport source (output valid, command, key_code, flag_value, input ready);
  modport sink   (input valid, command, key_code, flag_value, output ready);
endinterface

interface tkcs_rpt_if import tkcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] report_kind;
  logic [KEY_W-1:0]  report_key;

  modport source (output valid, report_kind, report_key, input ready);
  modport sink   (input valid, report_kind, report_key, output ready);
endinterface

`default_nettype wire

@@ design/tkcs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tkcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/typematic_key_change_scanner_top.sv @@
// Typematic key change scanner, top level.
// Depends on tkcs_pkg, tkcs_req_if / tkcs_rpt_if and tkcs_ram.
//
// Usage:
//  - request channel (valid/ready): command, key_code, flag_value. A press or
//    release that changes a key, and a repeat tick whose countdown is zero,
//    start a circular scan of the key table; each such request gives zero or
//    one report. Flag writes, ignored presses/releases and ticks that only
//    count down give no report.
//  - report channel (valid/ready): report_kind, report_key, held in an output
//    register until taken.
//  - config port: cfg_we, cfg_index, cfg_data; write while idle, values clamped.
// Timing: a request is taken only in the idle state. Flag writes and no-change
// presses/releases pass through the check state; a counting tick stays idle. A
// changing press/release runs the delay/period divider (one bit per cycle) after
// the check, then the scan; the scan visits one key per cycle through the table
// RAM read port and reads at most KEY_COUNT keys.
// A scan starts only once the output register is free, so a stalled receiver
// holds a scanning request before the scan; requests without reports continue.
// Reset clears the key table through per-entry valid bits, the scan position
// and countdown, and loads period 33 and delay 490.
`timescale 1ns / 1ps
`default_nettype none

module typematic_key_change_scanner_top import tkcs_pkg::*; #(
  parameter int KEY_COUNT = KEY_COUNT_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data,
  tkcs_req_if.sink             request,
  tkcs_rpt_if.source           report
);

  localparam int KW    = $clog2(KEY_COUNT);
  localparam int CNT_W = KW + 1;
  localparam int CMP_W = KEY_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(KEY_COUNT);
  localparam logic [KW-1:0]    KEY_LAST = KW'(KEY_COUNT - 1);

  // control and datapath registers
  tkcs_state_t          state, state_next;
  logic [PERIOD_W-1:0]  period;
  logic [DELAY_W-1:0]   delay;
  logic [COUNT_W-1:0]   countdown;
  logic [KW-1:0]        scan_pos;
  logic [CMD_W-1:0]     cmd;
  logic [KW-1:0]        key;
  logic                 flag;
  logic                 scan_tick;
  logic [KW-1:0]        scan_addr;
  logic [CNT_W-1:0]     issue_cnt;
  logic                 chk_pend;
  logic [KW-1:0]        chk_key;
  logic [KEY_COUNT-1:0] entry_vld;
  logic                 rd_vld;
  logic [PERIOD_W-1:0]  div_rem;
  logic [DELAY_W-1:0]   div_dvd;
  logic [DELAY_W-1:0]   div_q;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 res_valid;
  logic [KIND_W-1:0]    res_kind;
  logic [KEY_W-1:0]     res_key;

  // RAM ports and decode
  logic               ram_we;
  logic [KW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [KW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] entry;
  logic               key_ok;
  logic               accept;
  logic               want;
  logic               key_change;
  logic               scan_change;
  logic               scan_rep;
  logic               scan_hit;
  logic               scan_issue;
  logic               scan_end;
  logic               scan_start;
  logic               out_free;
  logic [KW-1:0]      start_key;
  logic [KW-1:0]      addr_inc;

  // divider step wires
  logic [PERIOD_W:0]    div_trial;
  logic                 div_ge;
  logic [PERIOD_W-1:0]  div_rem_next;
  logic [DELAY_W-1:0]   div_q_next;

  tkcs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (KEY_COUNT)
  ) u_key_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entry that was never written reads as all zero
  assign entry = rd_vld ? ram_rdata : '0;

  assign key_ok   = ({1'b0, request.key_code} < CMP_W'(KEY_COUNT));
  assign accept   = request.valid && request.ready;
  assign want     = (cmd == CMD_PRESS);
  assign out_free = !res_valid || report.ready;

  // circular key successors
  assign start_key = (scan_pos == KEY_LAST) ? '0 : scan_pos + 1'b1;
  assign addr_inc  = (scan_addr == KEY_LAST) ? '0 : scan_addr + 1'b1;

  // scan evaluation of the key whose entry just came back
  assign scan_change = chk_pend && (entry[BIT_HELD] != entry[BIT_REPORTED]);
  assign scan_rep    = chk_pend && !scan_change && scan_tick &&
                       entry[BIT_HELD] && entry[BIT_REPEAT];
  assign scan_hit    = scan_change || scan_rep;
  assign key_change  = (cmd != CMD_FLAG) && (entry[BIT_HELD] != want);

  // divider step: delay / period, one quotient bit per cycle
  assign div_trial    = {div_rem, div_dvd[DELAY_W-1]};
  assign div_ge       = (div_trial >= {1'b0, period});
  assign div_rem_next = div_ge ? PERIOD_W'(div_trial - {1'b0, period})
                               : div_trial[PERIOD_W-1:0];
  assign div_q_next   = {div_q[DELAY_W-2:0], div_ge};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (request.command == CMD_TICK) begin
            state_next = (countdown != '0) ? S_IDLE : S_WAIT;
          end else begin
            state_next = key_ok ? S_CHECK : S_IDLE;
          end
        end
      end
      S_CHECK: begin
        state_next = key_change ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake, table access, scan control
  always_comb begin
    request.ready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = key;
    ram_wdata     = entry;
    ram_raddr     = scan_addr;
    scan_issue    = 1'b0;
    scan_end      = 1'b0;
    scan_start    = 1'b0;
    case (state)
      S_IDLE: begin
        request.ready = 1'b1;
        ram_raddr     = request.key_code[KW-1:0];
      end
      S_CHECK: begin
        if (cmd == CMD_FLAG) begin
          ram_we                = 1'b1;
          ram_wdata[BIT_REPEAT] = flag;
        end else if (key_change) begin
          ram_we              = 1'b1;
          ram_wdata[BIT_HELD] = want;
        end
      end
      S_WAIT: begin
        scan_start = out_free;
      end
      S_SCAN: begin
        ram_waddr  = chk_key;
        scan_issue = !scan_hit && (issue_cnt != CNT_MAX);
        scan_end   = !chk_pend && (issue_cnt == CNT_MAX);
        if (scan_change) begin
          ram_we                  = 1'b1;
          ram_wdata[BIT_REPORTED] = entry[BIT_HELD];
        end
      end
      default: begin
        request.ready = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers, clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
      delay  <= DELAY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD: begin
          if (cfg_data[PERIOD_W-1:0] < PERIOD_MIN) begin
            period <= PERIOD_MIN;
          end else if (cfg_data[PERIOD_W-1:0] > PERIOD_MAX) begin
            period <= PERIOD_MAX;
          end else begin
            period <= cfg_data[PERIOD_W-1:0];
          end
        end
        REG_DELAY: begin
          if (cfg_data < DELAY_MIN) begin
            delay <= DELAY_MIN;
          end else if (cfg_data > DELAY_MAX) begin
            delay <= DELAY_MAX;
          end else begin
            delay <= cfg_data;
          end
        end
        default: begin
          period <= period;
        end
      endcase
    end
  end

  // table entry valid bits and registered valid for the read port
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (ram_we) begin
        entry_vld[ram_waddr] <= 1'b1;
      end
      rd_vld <= entry_vld[ram_raddr];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd       <= request.command;
      key       <= request.key_code[KW-1:0];
      flag      <= request.flag_value;
      scan_tick <= (request.command == CMD_TICK);
    end
  end

  // countdown: reload from divider, decrement on tick
  always_ff @(posedge clk) begin
    if (rst) begin
      countdown <= '0;
    end else if (accept && request.command == CMD_TICK && countdown != '0) begin
      countdown <= countdown - 1'b1;
    end else if (state == S_DIV && div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
      countdown <= div_q_next[COUNT_W-1:0];
    end
  end

  // divider iteration
  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      div_rem <= '0;
      div_dvd <= delay;
      div_q   <= '0;
      div_cnt <= '0;
    end else if (state == S_DIV) begin
      div_rem <= div_rem_next;
      div_dvd <= {div_dvd[DELAY_W-2:0], 1'b0};
      div_q   <= div_q_next;
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // scan pipeline: issue one read per cycle, check it the next
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_pend  <= 1'b0;
      issue_cnt <= '0;
    end else if (scan_start) begin
      scan_addr <= start_key;
      issue_cnt <= '0;
      chk_pend  <= 1'b0;
    end else if (state == S_SCAN) begin
      chk_pend <= scan_issue;
      if (scan_issue) begin
        chk_key   <= scan_addr;
        scan_addr <= addr_inc;
        issue_cnt <= issue_cnt + 1'b1;
      end
    end
  end

  // scan position follows the reported key
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos <= '0;
    end else if (state == S_SCAN && scan_hit) begin
      scan_pos <= chk_key;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_SCAN && scan_hit) begin
      res_valid <= 1'b1;
    end else if (report.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && scan_hit) begin
      res_key <= KEY_W'(chk_key);
      if (scan_rep) begin
        res_kind <= KIND_REPEAT;
      end else if (entry[BIT_HELD]) begin
        res_kind <= KIND_DOWN;
      end else begin
        res_kind <= KIND_UP;
      end
    end
  end

  assign report.valid       = res_valid;
  assign report.report_kind = res_kind;
  assign report.report_key  = res_key;

  // a report is only produced by the scan
  a_report_from_scan: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !$past(res_valid)) |-> ($past(state) == S_SCAN))
    else $error("report loaded outside the scan");

  // a scan never starts while the output register is occupied
  a_scan_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && $past(state) == S_WAIT) |-> !res_valid)
    else $error("scan started with a pending report");

  // the scan never visits more keys than the table holds
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issue_cnt <= CNT_MAX))
    else $error("scan issued too many reads");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_rem < period))
    else $error("divider remainder out of range");

endmodule

`default_nettype wire

@@ tb/sv/typematic_key_change_scanner_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the typematic key change scanner: directed key, tick and flag requests,
// register clamping, a long report stall and random typing traffic, checked against a key map model.
// Depends on tkcs_pkg, the tkcs_req_if / tkcs_rpt_if interfaces and typematic_key_change_scanner_top.

module typematic_key_change_scanner_top_tb;
  import tkcs_pkg::*;

  localparam int NUM_KEYS      = 256;
  localparam int SETTLE_CYCLES = 320;
  localparam int HOLD_OFF_LEN  = 3000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
  } key_report_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tkcs_req_if request_ch ();
  tkcs_rpt_if report_ch ();

  typematic_key_change_scanner_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request_ch),
    .report    (report_ch)
  );

  // key map model state
  logic [NUM_KEYS-1:0] held_keys;
  logic [NUM_KEYS-1:0] reported_keys;
  logic [NUM_KEYS-1:0] repeatable_keys;
  logic [KEY_W-1:0]    last_scan_key;
  logic [COUNT_W-1:0]  tick_countdown;
  logic [PERIOD_W-1:0] repeat_period;
  logic [DELAY_W-1:0]  repeat_delay;
  key_report_t         pending_reports[$];
  key_report_t         want_rpt;

  int error_count     = 0;
  int send_idle_pct   = 0;
  int stall_pct       = 0;
  int hold_off_cycles = 0;
  int held_so_far     = 0;
  bit request_took_effect;

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // circular scan from the key after the last reported one
  function automatic void scan_for_report(input bit tick);
    logic [KEY_W-1:0] k;
    k = last_scan_key;
    for (int n = 0; n < NUM_KEYS; n++) begin
      k = k + 1'b1;
      if (held_keys[k] != reported_keys[k]) begin
        pending_reports.push_back(key_report_t'{held_keys[k] ? KIND_DOWN : KIND_UP, k});
        reported_keys[k] = held_keys[k];
        last_scan_key = k;
        return;
      end
      if (tick && held_keys[k] && repeatable_keys[k]) begin
        pending_reports.push_back(key_report_t'{KIND_REPEAT, k});
        last_scan_key = k;
        return;
      end
    end
  endfunction

  // model update for one accepted request; returns 0 when the request is ignored
  function automatic bit apply_key_request(input logic [CMD_W-1:0] cmd,
                                           input logic [KEY_W-1:0] key,
                                           input logic flag);
    logic want_held;
    apply_key_request = 1'b1;
    case (cmd)
      CMD_PRESS, CMD_RELEASE: begin
        want_held = (cmd == CMD_PRESS);
        if (held_keys[key] == want_held) begin
          apply_key_request = 1'b0;
        end else begin
          held_keys[key] = want_held;
          tick_countdown = COUNT_W'(repeat_delay / repeat_period);
          scan_for_report(1'b0);
        end
      end
      CMD_TICK: begin
        if (tick_countdown != 0) tick_countdown = tick_countdown - 1'b1;
        else scan_for_report(1'b1);
      end
      default: begin
        repeatable_keys[key] = flag;
      end
    endcase
  endfunction

  // clamped register update
  function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    logic [PERIOD_W-1:0] p;
    p = data[PERIOD_W-1:0];
    if (idx == REG_PERIOD) begin
      if (p < PERIOD_MIN) repeat_period = PERIOD_MIN;
      else if (p > PERIOD_MAX) repeat_period = PERIOD_MAX;
      else repeat_period = p;
    end else begin
      if (data < DELAY_MIN) repeat_delay = DELAY_MIN;
      else if (data > DELAY_MAX) repeat_delay = DELAY_MAX;
      else repeat_delay = data;
    end
  endfunction

  // offer one request, with random idle cycles ahead of it
  task automatic send_key_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                  input logic flag);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      request_ch.valid <= 1'b0;
      @(posedge clk);
    end
    request_ch.valid      <= 1'b1;
    request_ch.command    <= cmd;
    request_ch.key_code   <= key;
    request_ch.flag_value <= flag;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
    request_took_effect = apply_key_request(cmd, key, flag);
  endtask

  // wait for all reports, then for any scan that gives none to finish
  task automatic settle();
    request_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_config(idx, data);
    cfg_we <= 1'b0;
  endtask

  // edge keys, ignored presses and releases, flag writes, countdown and repeat at reset timing
  task automatic test_directed_cases();
    send_key_request(CMD_PRESS, 8'h00, 1'b0);
    send_key_request(CMD_PRESS, 8'h00, 1'b1);
    send_key_request(CMD_PRESS, 8'hFF, 1'b0);
    send_key_request(CMD_RELEASE, 8'hFF, 1'b1);
    send_key_request(CMD_RELEASE, 8'hFF, 1'b0);
    send_key_request(CMD_FLAG, 8'h00, 1'b1);
    send_key_request(CMD_FLAG, 8'hFF, 1'b1);
    send_key_request(CMD_FLAG, 8'hFF, 1'b0);
    // countdown runs out, then repeats of key 0
    repeat (16) send_key_request(CMD_TICK, KEY_W'($urandom), 1'($urandom));
    send_key_request(CMD_RELEASE, 8'h00, 1'b0);
  endtask

  // clamped settings, then the tick count until the first repeat
  task automatic test_config_clamping();
    logic [CFG_DATA_W-1:0] period_vals[8] = '{10'h000, 10'h3FF, 10'd14, 10'd101,
                                              10'd15, 10'd100, 10'h3A8, 10'd0};
    logic [CFG_DATA_W-1:0] delay_vals[8]  = '{10'h000, 10'h3FF, 10'd249, 10'd1001,
                                              10'd250, 10'd1000, 10'h0FF, 10'd1000};
    logic [KEY_W-1:0] k;
    int n;
    for (int i = 0; i < 8; i++) begin
      k = KEY_W'($urandom);
      write_config(REG_PERIOD, period_vals[i]);
      write_config(REG_DELAY, delay_vals[i]);
      send_key_request(CMD_FLAG, k, 1'b1);
      send_key_request(CMD_PRESS, k, 1'b0);
      n = tick_countdown;
      repeat (n + 2) send_key_request(CMD_TICK, KEY_W'($urandom), 1'b0);
      send_key_request(CMD_RELEASE, k, 1'b0);
      send_key_request(CMD_FLAG, k, 1'b0);
    end
  endtask

  // receiver holds off while key changes keep coming, so requests back up
  task automatic test_report_backpressure();
    logic [KEY_W-1:0] k;
    hold_off_cycles = HOLD_OFF_LEN;
    repeat (16) begin
      k = KEY_W'($urandom);
      send_key_request(held_keys[k] ? CMD_RELEASE : CMD_PRESS, k, 1'b0);
    end
    while (held_so_far < hold_off_cycles) @(posedge clk);
    hold_off_cycles = 0;
  endtask

  // typing bursts on a small key pool: one change then a run of ticks, plus noise
  task automatic test_random_traffic(input int num_items, input int idle_pct, input int stall);
    logic [KEY_W-1:0] key_pool[6];
    logic [KEY_W-1:0] k;
    int done_items;
    int r;
    write_config(REG_PERIOD, CFG_DATA_W'($urandom_range(60, 100)));
    write_config(REG_DELAY, CFG_DATA_W'($urandom_range(250, 400)));
    send_idle_pct = idle_pct;
    stall_pct = stall;
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
    done_items = 0;
    while (done_items < num_items) begin
      r = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, 5)];
      if (r < 70) begin
        send_key_request(held_keys[k] ? CMD_RELEASE : CMD_PRESS, k, 1'($urandom));
        if (request_took_effect) done_items++;
        repeat ($urandom_range(0, 12)) begin
          send_key_request(CMD_TICK, KEY_W'($urandom), 1'($urandom));
          done_items++;
        end
      end else if (r < 85) begin
        send_key_request(CMD_FLAG, k, 1'($urandom_range(0, 1)));
        done_items++;
      end else begin
        send_key_request(CMD_W'($urandom), KEY_W'($urandom), 1'($urandom));
        if (request_took_effect) done_items++;
      end
    end
  endtask

  // receiver ready: long hold-off when requested, else random stalls
  always @(posedge clk) begin
    if (rst) begin
      report_ch.ready <= 1'b0;
    end else if (hold_off_cycles != 0 && held_so_far < hold_off_cycles) begin
      held_so_far <= held_so_far + 1;
      report_ch.ready <= 1'b0;
    end else begin
      if (hold_off_cycles == 0) held_so_far <= 0;
      report_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // report checker
  always @(posedge clk) begin
    if (!rst && report_ch.valid && report_ch.ready) begin
      if (pending_reports.size() == 0) begin
        error_count++;
        $display("%0t: expected no report, actual kind %0d key %0d", $time,
                 report_ch.report_kind, report_ch.report_key);
      end else begin
        want_rpt = pending_reports.pop_front();
        if (report_ch.report_kind !== want_rpt.kind) begin
          error_count++;
          $display("%0t: report_kind expected %0d actual %0d", $time, want_rpt.kind,
                   report_ch.report_kind);
        end
        if (report_ch.report_key !== want_rpt.key) begin
          error_count++;
          $display("%0t: report_key expected %0d actual %0d", $time, want_rpt.key,
                   report_ch.report_key);
        end
      end
    end
  end

  // test sequence
  initial begin
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_PERIOD;
    cfg_data              <= '0;
    request_ch.valid      <= 1'b0;
    request_ch.command    <= CMD_PRESS;
    request_ch.key_code   <= '0;
    request_ch.flag_value <= 1'b0;
    held_keys       = '0;
    reported_keys   = '0;
    repeatable_keys = '0;
    last_scan_key   = '0;
    tick_countdown  = '0;
    repeat_period   = PERIOD_RESET;
    repeat_delay    = DELAY_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_config_clamping();
    test_report_backpressure();
    test_random_traffic(430, 0, 0);
    test_random_traffic(430, 82, 0);
    test_random_traffic(430, 0, 82);
    test_random_traffic(430, 26, 26);
    settle();

    if (error_count == 0) begin
      $display("[typematic_key_change_scanner_top] OK");
    end else begin
      $display("[typematic_key_change_scanner_top] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("[typematic_key_change_scanner_top] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
design/tkcs_pkg.sv
design/tkcs_if.sv
design/tkcs_ram.sv
design/typematic_key_change_scanner_top.sv
tb/sv/typematic_key_change_scanner_top_tb.sv
